>>> rtl/running_mean_variance_assert.svh
// Assertion macros for the running mean/variance block.
// Used by running_mean_variance.sv; no other dependencies.
`ifndef RUNNING_MEAN_VARIANCE_ASSERT_SVH
`define RUNNING_MEAN_VARIANCE_ASSERT_SVH
`ifndef SYNTHESIS
`define RMV_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define RMV_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define RMV_ASSERT_IMP(label, clk, rst_n, a, c)
`define RMV_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

>>> rtl/rmv_pkg.sv
// Package for the running mean/variance block: state codes and fixed widths.
// No dependencies.
`default_nettype none
package rmv_pkg;
  localparam int unsigned SAMPLE_W = 32;
  localparam int unsigned VAR_W    = 48;
  localparam int unsigned SUM_W    = 64;

  localparam logic [1:0] MODE_STORE_ACC = 2'd0;
  localparam logic [1:0] MODE_STORE     = 2'd1;
  localparam logic [1:0] MODE_ACC       = 2'd2;
  // no update, report only
  localparam logic [1:0] MODE_REPORT    = 2'd3;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_DIV1  = 9'b000000010,
    ST_MUL   = 9'b000000100,
    ST_MUL2  = 9'b000001000,
    ST_STAT  = 9'b000010000,
    ST_DIV2  = 9'b000100000,
    ST_SQRT  = 9'b001000000,
    ST_DONE  = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_t;
endpackage
`default_nettype wire

>>> rtl/running_mean_variance.sv
// Running mean/variance (Welford) top level with one shared shift-subtract unit.
// Depends on rmv_pkg and running_mean_variance_assert.svh.
//
// Usage: in_sample (signed Q16.16) and in_mode enter on a valid/ready
// transaction. Mode 0 stores and accumulates, mode 1 stores only, mode 2
// accumulates the stored value, mode 3 only reports. Each transaction
// yields one result on out_*: stored value, count, mean, sample variance
// (Q32.16) and standard deviation (Q16.16).
// Path to out_valid for an accumulating item: mean division (33 quotient
// bits), product, sum update, setup, variance division (64 quotient bits),
// square root (32 result bits), finish state. Without accumulation it starts
// at setup; with a count below two, setup goes straight to the finish state.
// The divisions and the root share one restoring unit, one bit per cycle.
// in_ready is high only in idle; one item is in flight at a time, so the
// block takes no new item before the last one's result is taken.
// The result sits in an output register; if the receiver stalls the block
// holds it and takes no new item until it is taken.
// Reset (synchronous, rst_n low) clears count, mean, sum and stored value.
`default_nettype none
module running_mean_variance #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [rmv_pkg::SAMPLE_W-1:0] in_sample,
  input  wire logic [1:0]                    in_mode,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed [rmv_pkg::SAMPLE_W-1:0] out_current_value,
  output logic [31:0]                        out_sample_count,
  output logic signed [rmv_pkg::SAMPLE_W-1:0] out_running_mean,
  output logic [rmv_pkg::VAR_W-1:0]          out_sample_variance,
  output logic [31:0]                        out_std_deviation
);
  import rmv_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  state_t state_r, state_nxt;
  logic signed [31:0] last_r, last_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic signed [31:0] mean_r, mean_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic mneg_r, mneg_nxt;
  logic [32:0] mag_r, mag_nxt;
  logic [65:0] prod_r, prod_nxt;
  // shared restoring unit: remainder, working value (quotient/dividend), divisor
  logic [64:0] rem_r, rem_nxt;
  logic [63:0] qw_r, qw_nxt;
  logic [63:0] dv_r, dv_nxt;
  logic [6:0]  it_r, it_nxt;
  logic [VAR_W-1:0] var_r, var_nxt;
  logic [31:0] sd_r, sd_nxt;

  // one trial subtract per cycle, used by division and square root
  logic [64:0] trial;
  logic [64:0] sub_a, sub_b;
  logic [65:0] sum_ext;
  logic [32:0] q33;
  logic [32:0] rest;

  assign in_ready = (state_r == ST_IDLE);
  assign sum_ext  = {2'b0, sum_r} + {16'd0, prod_r[65:16]};
  assign q33      = qw_r[32:0];
  assign rest     = mag_r - q33;

  always_comb begin
    sub_a = 65'd0;
    sub_b = 65'd0;
    case (state_r)
      ST_SQRT: begin
        sub_a = {rem_r[62:0], qw_r[63:62]};
        sub_b = {31'd0, sd_r, 2'b01};
      end
      default: begin
        sub_a = {rem_r[63:0], qw_r[63]};
        sub_b = {1'b0, dv_r};
      end
    endcase
    trial = sub_a - sub_b;
  end

  always_comb begin
    state_nxt = state_r;
    last_nxt = last_r; cnt_nxt = cnt_r; mean_nxt = mean_r; sum_nxt = sum_r;
    mneg_nxt = mneg_r; mag_nxt = mag_r; prod_nxt = prod_r;
    rem_nxt = rem_r; qw_nxt = qw_r; dv_nxt = dv_r; it_nxt = it_r;
    var_nxt = var_r; sd_nxt = sd_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          logic signed [31:0] x;
          logic signed [32:0] d;
          x = (in_mode == MODE_STORE_ACC || in_mode == MODE_STORE) ? in_sample : last_r;
          last_nxt = x;
          d = {x[31], x} - {mean_r[31], mean_r};
          mneg_nxt = d[32];
          mag_nxt = d[32] ? 33'(-d) : 33'(d);
          rem_nxt = '0;
          it_nxt = '0;
          if ((in_mode == MODE_STORE_ACC || in_mode == MODE_ACC) && cnt_r != CNT_MAX) begin
            qw_nxt = {d[32] ? 33'(-d) : 33'(d), 31'd0};
            dv_nxt = 64'(cnt_r) + 64'd1;
            state_nxt = ST_DIV1;
          end else begin
            state_nxt = ST_STAT;
          end
        end
      end
      ST_DIV1: begin
        // 33 bits of quotient
        if (!trial[64]) begin
          rem_nxt = trial;
          qw_nxt = {qw_r[62:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[63:0], qw_r[63]};
          qw_nxt = {qw_r[62:0], 1'b0};
        end
        it_nxt = it_r + 7'd1;
        if (it_r == 7'd32) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        prod_nxt = 66'(mag_r) * 66'(rest);
        mean_nxt = mneg_r ? 32'(mean_r - signed'(q33[31:0])) : 32'(mean_r + signed'(q33[31:0]));
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        sum_nxt = sum_ext[64] ? '1 : sum_ext[63:0];
        cnt_nxt = cnt_r + 1'b1;
        state_nxt = ST_STAT;
      end
      ST_STAT: begin
        var_nxt = '0; sd_nxt = '0;
        rem_nxt = '0; it_nxt = '0;
        if (cnt_r >= COUNT_BITS'(2)) begin
          qw_nxt = sum_r;
          dv_nxt = 64'(cnt_r) - 64'd1;
          state_nxt = ST_DIV2;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DIV2: begin
        if (!trial[64]) begin
          rem_nxt = trial;
          qw_nxt = {qw_r[62:0], 1'b1};
        end else begin
          rem_nxt = {rem_r[63:0], qw_r[63]};
          qw_nxt = {qw_r[62:0], 1'b0};
        end
        it_nxt = it_r + 7'd1;
        if (it_r == 7'd63) begin
          var_nxt = (|qw_nxt[63:48]) ? '1 : qw_nxt[47:0];
          qw_nxt = {((|qw_nxt[63:48]) ? {VAR_W{1'b1}} : qw_nxt[47:0]), 16'd0};
          rem_nxt = '0; it_nxt = '0; sd_nxt = '0;
          state_nxt = ST_SQRT;
        end
      end
      ST_SQRT: begin
        // digit-by-digit root, 2 radicand bits per step
        if (!trial[64]) begin
          rem_nxt = trial;
          sd_nxt = {sd_r[30:0], 1'b1};
        end else begin
          rem_nxt = sub_a;
          sd_nxt = {sd_r[30:0], 1'b0};
        end
        qw_nxt = {qw_r[61:0], 2'b00};
        it_nxt = it_r + 7'd1;
        if (it_r == 7'd31) state_nxt = ST_DONE;
      end
      ST_DONE: state_nxt = ST_OUT;
      ST_OUT: if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      last_r <= '0; cnt_r <= '0; mean_r <= '0; sum_r <= '0;
    end else begin
      state_r <= state_nxt;
      last_r <= last_nxt; cnt_r <= cnt_nxt; mean_r <= mean_nxt; sum_r <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mneg_r <= mneg_nxt; mag_r <= mag_nxt; prod_r <= prod_nxt;
    rem_r <= rem_nxt; qw_r <= qw_nxt; dv_r <= dv_nxt; it_r <= it_nxt;
    var_r <= var_nxt; sd_r <= sd_nxt;
  end

  assign out_valid           = (state_r == ST_OUT);
  assign out_current_value   = last_r;
  assign out_sample_count    = 32'(cnt_r);
  assign out_running_mean    = mean_r;
  assign out_sample_variance = var_r;
  assign out_std_deviation   = sd_r;

  `include "running_mean_variance_assert.svh"
  `RMV_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ready, !out_valid)
  `RMV_ASSERT_NXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_sample_variance))
  `RMV_ASSERT_NXT(a_cnt_fixed, clk, rst_n, in_ready && !in_valid, $stable(out_sample_count))
endmodule
`default_nettype wire
